// ----- design/resp_bulk_string_framer_unit_assert.svh -----
// -----------------------------------------------------------------------------
// resp_bulk_string_framer_unit_assert.svh
// Assertion macros used by the checker file of the framer.
// -----------------------------------------------------------------------------
`ifndef RESP_BULK_STRING_FRAMER_UNIT_ASSERT_SVH
`define RESP_BULK_STRING_FRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define RBSF_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("framer assertion failed");

// Next-cycle implication, disabled while reset is low.
`define RBSF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("framer assertion failed");

`endif

// ----- design/rbsf_pkg.sv -----
// -----------------------------------------------------------------------------
// rbsf_pkg
// Shared types and constants of the RESP bulk string framer.
// -----------------------------------------------------------------------------
package rbsf_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 64;
  localparam int unsigned VALUE_W         = 64;
  localparam int unsigned BYTE_W          = 8;

  // request kinds
  localparam logic [1:0] ACT_ARRAY = 2'd0;
  localparam logic [1:0] ACT_BULK  = 2'd1;
  localparam logic [1:0] ACT_DATA  = 2'd2;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // source of the byte loaded into the output register
  typedef enum logic [2:0] {
    SEL_NONE,
    SEL_LEAD,
    SEL_DIGIT,
    SEL_CR,
    SEL_LF,
    SEL_DATA
  } rbsf_sel_t;

  typedef struct packed {
    logic      load;
    logic      conv_step;
    logic      dig_shift;
    logic      emit;
    rbsf_sel_t sel;
    logic      last;
    logic      err;
  } rbsf_cmd_t;

  typedef struct packed {
    logic bad;
    logic is_data;
    logic rem_zero;
    logic bulk;
    logic conv_last;
    logic top_zero;
    logic one_digit;
    logic out_free;
  } rbsf_sts_t;

endpackage

// ----- design/rbsf_ctrl.sv -----
// -----------------------------------------------------------------------------
// rbsf_ctrl
// Sequencer of the framer: accepts a request, then walks the lead, decimal
// conversion, zero-skip, digit, CR LF, payload and error steps.
// -----------------------------------------------------------------------------
module rbsf_ctrl
  import rbsf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  rbsf_sts_t sts,
  output rbsf_cmd_t cmd
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_ERR   = 11'b000_0000_0010,
    S_LEAD  = 11'b000_0000_0100,
    S_CONV  = 11'b000_0000_1000,
    S_SKIP  = 11'b000_0001_0000,
    S_DIGIT = 11'b000_0010_0000,
    S_CR    = 11'b000_0100_0000,
    S_LF    = 11'b000_1000_0000,
    S_ZCR   = 11'b001_0000_0000,
    S_ZLF   = 11'b010_0000_0000,
    S_DATA  = 11'b100_0000_0000
  } rbsf_state_t;

  rbsf_state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.sel   = SEL_NONE;
    case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          if (sts.bad) begin
            state_nxt = S_ERR;
          end else if (sts.is_data) begin
            state_nxt = S_DATA;
          end else begin
            state_nxt = S_LEAD;
          end
        end
      end
      S_ERR: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_NONE;
          cmd.last  = 1'b1;
          cmd.err   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_LEAD: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_LEAD;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        cmd.conv_step = 1'b1;
        if (sts.conv_last) begin
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        // drop leading zeros, always keep the units digit
        if (sts.top_zero && !sts.one_digit) begin
          cmd.dig_shift = 1'b1;
        end else begin
          state_nxt = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.sel       = SEL_DIGIT;
          cmd.dig_shift = 1'b1;
          if (sts.one_digit) begin
            state_nxt = S_CR;
          end
        end
      end
      S_CR: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_CR;
          state_nxt = S_LF;
        end
      end
      S_LF: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = SEL_LF;
          // empty bulk string closes at once
          cmd.last = !(sts.bulk && sts.rem_zero);
          state_nxt = (sts.bulk && sts.rem_zero) ? S_ZCR : S_IDLE;
        end
      end
      S_ZCR: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_CR;
          state_nxt = S_ZLF;
        end
      end
      S_ZLF: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_LF;
          cmd.last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DATA: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_DATA;
          cmd.last  = !sts.rem_zero;
          state_nxt = sts.rem_zero ? S_ZCR : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- design/rbsf_dpath.sv -----
// -----------------------------------------------------------------------------
// rbsf_dpath
// Datapath of the framer: remaining-bytes counter, bit-serial binary to BCD
// converter, digit shifter and the output register.
// -----------------------------------------------------------------------------
module rbsf_dpath
  import rbsf_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         in_action,
  input  logic [VALUE_W-1:0] in_value,
  input  logic [BYTE_W-1:0]  in_data_byte,
  input  logic               out_stall,
  output logic               out_valid,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               out_last,
  output logic               out_protocol_error,
  input  rbsf_cmd_t          cmd,
  output rbsf_sts_t          sts
);

  // decimal digits of 2**LENGTH_BITS - 1
  localparam int unsigned NDIG   = (LENGTH_BITS * 77) / 256 + 1;
  localparam int unsigned BCD_W  = 4 * NDIG;
  localparam int unsigned CNT_W  = $clog2(LENGTH_BITS + 1);
  localparam int unsigned DCNT_W = $clog2(NDIG + 1);

  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic [LENGTH_BITS-1:0] bin_r;
  logic [BCD_W-1:0]       bcd_r;
  logic [BCD_W-1:0]       bcd_adj;
  logic [CNT_W-1:0]       bit_cnt_r;
  logic [DCNT_W-1:0]      dig_cnt_r;
  logic [7:0]             lead_r;
  logic [7:0]             data_r;
  logic                   bulk_r;
  logic                   out_valid_r;
  logic [7:0]             out_byte_r;
  logic                   out_last_r;
  logic                   out_err_r;
  logic [LENGTH_BITS-1:0] val_in;
  logic                   bad;
  logic [3:0]             top_dig;
  logic [7:0]             emit_byte;

  assign val_in  = in_value[LENGTH_BITS-1:0];
  assign top_dig = bcd_r[BCD_W-1 -: 4];

  always_comb begin
    case (in_action)
      ACT_ARRAY, ACT_BULK: bad = (rem_r != '0);
      ACT_DATA:            bad = (rem_r == '0);
      default:             bad = 1'b1;
    endcase
  end

  always_comb begin
    rem_nxt = rem_r;
    if (cmd.load && !bad) begin
      if (in_action == ACT_BULK) begin
        rem_nxt = val_in;
      end else if (in_action == ACT_DATA) begin
        rem_nxt = rem_r - LENGTH_BITS'(1);
      end
    end
  end

  // add-3 correction on every digit ahead of the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    case (cmd.sel)
      SEL_LEAD:  emit_byte = lead_r;
      SEL_DIGIT: emit_byte = CH_ZERO + {4'd0, top_dig};
      SEL_CR:    emit_byte = CH_CR;
      SEL_LF:    emit_byte = CH_LF;
      SEL_DATA:  emit_byte = data_r;
      default:   emit_byte = CH_NUL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rem_r <= rem_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin_r     <= val_in;
      bcd_r     <= '0;
      bit_cnt_r <= CNT_W'(LENGTH_BITS);
      dig_cnt_r <= DCNT_W'(NDIG);
      lead_r    <= (in_action == ACT_BULK) ? CH_DOLLAR : CH_STAR;
      data_r    <= in_data_byte;
      bulk_r    <= (in_action == ACT_BULK);
    end else if (cmd.conv_step) begin
      bcd_r     <= {bcd_adj[BCD_W-2:0], bin_r[LENGTH_BITS-1]};
      bin_r     <= {bin_r[LENGTH_BITS-2:0], 1'b0};
      bit_cnt_r <= bit_cnt_r - CNT_W'(1);
    end else if (cmd.dig_shift) begin
      bcd_r     <= {bcd_r[BCD_W-5:0], 4'd0};
      dig_cnt_r <= dig_cnt_r - DCNT_W'(1);
    end
    if (cmd.emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= cmd.last;
      out_err_r  <= cmd.err;
    end
  end

  always_comb begin
    sts.bad       = bad;
    sts.is_data   = (in_action == ACT_DATA);
    sts.rem_zero  = (rem_r == '0);
    sts.bulk      = bulk_r;
    sts.conv_last = (bit_cnt_r == CNT_W'(1));
    sts.top_zero  = (top_dig == 4'd0);
    sts.one_digit = (dig_cnt_r == DCNT_W'(1));
    sts.out_free  = !out_valid_r || !out_stall;
  end

  assign out_valid          = out_valid_r;
  assign out_byte           = out_byte_r;
  assign out_last           = out_last_r;
  assign out_protocol_error = out_err_r;

endmodule

// ----- design/resp_bulk_string_framer_unit.sv -----
// -----------------------------------------------------------------------------
// resp_bulk_string_framer_unit
// Streaming RESP request-array framer: headers, payload bytes, CR LF closing.
// -----------------------------------------------------------------------------
// Takes one request at a time on the in_ channel and drives the encoded
// byte stream on the out_ channel, one byte per output request, with
// out_last on the final byte of each input request. An array header gives
// '*', the count in decimal and CR LF; a bulk header gives '$', the length
// and CR LF and arms the remaining-bytes counter (a zero length closes with
// CR LF at once); a payload byte passes through, and the byte that ends its
// component is followed by CR LF. A payload byte with nothing pending, a
// header inside a component or the unused action code yields one byte 0
// with out_last and out_protocol_error set and leaves the counter alone.
// Only the low LENGTH_BITS bits of in_value count. A header is converted by
// the bit-serial double-dabble converter, one input bit per cycle, into
// NDIG digits, NDIG being the decimal digits of 2**LENGTH_BITS - 1;
// suppressed leading zeros are then skipped before the digits go out.
// in_stall is high whenever a request is in progress.
// -----------------------------------------------------------------------------
module resp_bulk_string_framer_unit
  import rbsf_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // request input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic [VALUE_W-1:0] in_value,
  input  logic [BYTE_W-1:0]  in_data_byte,
  // encoded byte stream
  output logic               out_valid,
  input  logic               out_stall,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               out_last,
  output logic               out_protocol_error
);

  rbsf_cmd_t cmd;
  rbsf_sts_t sts;

  // sequencer: one-hot state machine, owns in_stall
  rbsf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // counter, converter and output register
  rbsf_dpath #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_action          (in_action),
    .in_value           (in_value),
    .in_data_byte       (in_data_byte),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_byte           (out_byte),
    .out_last           (out_last),
    .out_protocol_error (out_protocol_error),
    .cmd                (cmd),
    .sts                (sts)
  );

endmodule

// ----- design/rbsf_checker.sv -----
// -----------------------------------------------------------------------------
// rbsf_checker
// Port-level checks of the framer, bound to the top level.
// -----------------------------------------------------------------------------
`include "resp_bulk_string_framer_unit_assert.svh"

module rbsf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_action,
  input logic [63:0] in_value,
  input logic [7:0] in_data_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic       out_protocol_error
);

  // one request at a time: busy right after an accept
  `RBSF_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

  // more bytes of the same request still to come, so no new request taken
  `RBSF_ASSERT_NOW(a_busy_mid_request, clk, rst_n, out_valid && !out_last, in_stall)

  // rejection is a single zero byte
  `RBSF_ASSERT_NOW(a_error_form, clk, rst_n, out_valid && out_protocol_error, out_last && (out_byte == 8'h00))

  // stalled output holds
  `RBSF_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(out_last) && $stable(out_protocol_error))

endmodule

bind resp_bulk_string_framer_unit rbsf_checker u_rbsf_checker (.*);
